// ===== sv/process_lifetime_table_macros.svh =====
// Assertion macros for the process lifetime table checker.
// No dependencies; expects clk_i and rst_ni in the scope of use.
`ifndef PROCESS_LIFETIME_TABLE_MACROS_SVH
`define PROCESS_LIFETIME_TABLE_MACROS_SVH

// Same-cycle implication, disabled in reset
`define PLT_ASSERT_IMP(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) else $error(msg);

// Next-cycle implication, disabled in reset
`define PLT_ASSERT_NXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) else $error(msg);

`endif

// ===== sv/plt_pkg.sv =====
// Shared types and constants for the process lifetime table.
// No dependencies.
package plt_pkg;

  localparam int ENTRIES = 1024;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = IDX_W + 1;

  localparam logic [29:0] NS_PER_SEC   = 30'd1000000000;
  localparam logic [62:0] EVICT_RESET  = 63'd604800000000000;
  localparam logic [62:0] WINDOW_RESET = 63'd60000000000;

  localparam logic CFG_EVICT  = 1'b0;
  localparam logic CFG_WINDOW = 1'b1;

  typedef enum logic [1:0] {
    KIND_ADD     = 2'd0,
    KIND_GET     = 2'd1,
    KIND_PARENT  = 2'd2,
    KIND_CLEANUP = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SUB, S_SCAN, S_WRITE, S_DONE
  } state_e;

  typedef enum logic [2:0] {
    M_MATCH, M_GET, M_PARENT, M_PURGE, M_SHIFT
  } mode_e;

  typedef struct packed {
    logic [31:0] pid;
    logic [62:0] create;
    logic [62:0] exit_t;
    logic        exited;
    logic [63:0] payload;
  } rec_t;

endpackage

// ===== sv/plt_store.sv =====
// Record memory: one write port, one read port with registered read data.
// Depends on plt_pkg.
module plt_store (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [plt_pkg::IDX_W-1:0] waddr_i,
  input  plt_pkg::rec_t           wdata_i,
  input  logic [plt_pkg::IDX_W-1:0] raddr_i,
  output plt_pkg::rec_t           rdata_o
);

  plt_pkg::rec_t mem [plt_pkg::ENTRIES];
  plt_pkg::rec_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/process_lifetime_table.sv =====
// Process lifetime table: every word streams the table through the memory read
// port at one entry per cycle. Get and find parent scan the table once; cleanup
// computes the cutoff and then purges; an add scans for a match and writes, with
// an eviction purge when full and a shift-out when the purge frees no entry.
// One word is in work at a time; the next is taken the cycle after the result
// loads. Reset clears the fill count and config; the memory is not cleared.
module process_lifetime_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [62:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] pid_i,
  input  logic [62:0] create_time_i,
  input  logic [62:0] exit_time_i,
  input  logic        exited_i,
  input  logic [63:0] payload_i,
  input  logic [62:0] timestamp_i,
  input  logic [62:0] max_age_i,
  input  logic [31:0] now_sec_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic [31:0] found_pid_o,
  output logic [62:0] found_create_o,
  output logic [62:0] found_exit_o,
  output logic        found_exited_o,
  output logic [63:0] found_payload_o,
  output logic [10:0] entry_count_o
);

  localparam int IW = plt_pkg::IDX_W;
  localparam int CW = plt_pkg::CNT_W;

  plt_pkg::state_e state_q, state_d;
  plt_pkg::mode_e  mode_q, mode_d;
  logic            add_q, add_d;
  logic [CW-1:0]   fill_q, fill_d;
  logic [IW-1:0]   slot_q, slot_d;
  logic [62:0]     age_q, age_d;
  logic            scan_start, load_out, accept;

  logic [62:0]     evict_q, window_q;
  plt_pkg::rec_t   in_rec_q;
  logic [62:0]     ts_q;
  logic [31:0]     now_q;
  logic [61:0]     prod_q;
  logic [62:0]     cut_q;

  logic [CW-1:0]   rd_q, w_q;
  logic            issue, scan_done;
  logic            v1_q;
  logic [IW-1:0]   idx1_q;
  plt_pkg::rec_t   rdata;

  logic            v2_q, m_add2_q, m_get2_q, pre2_q, keep2_q;
  logic [IW-1:0]   idx2_q;
  plt_pkg::rec_t   rec2_q;
  logic [63:0]     sum2_q;
  logic [62:0]     diff2_q;

  logic            hit_q;
  logic [IW-1:0]   hit_idx_q;
  plt_pkg::rec_t   best_q;
  logic [62:0]     near_gap_q;

  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  plt_pkg::rec_t   mem_wdata;

  logic            out_valid_q;
  plt_pkg::rec_t   out_rec_q;
  logic            out_status_q;
  logic [10:0]     out_count_q;
  logic            found_ok;

  assign in_stall_o = (state_q != plt_pkg::S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign issue      = (state_q == plt_pkg::S_SCAN) && (rd_q < fill_q);
  assign scan_done  = (state_q == plt_pkg::S_SCAN) && (rd_q >= fill_q) && !v1_q && !v2_q;
  assign found_ok   = ((mode_q == plt_pkg::M_GET) || (mode_q == plt_pkg::M_PARENT)) && hit_q;

  plt_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (rd_q[IW-1:0]),
    .rdata_o (rdata)
  );

  // sequencer: next state, memory write and result strobe
  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    add_d      = add_q;
    fill_d     = fill_q;
    slot_d     = slot_q;
    age_d      = age_q;
    scan_start = 1'b0;
    load_out   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = w_q[IW-1:0];
    mem_wdata  = rec2_q;
    case (state_q)
      plt_pkg::S_IDLE: begin
        if (accept) begin
          case (plt_pkg::kind_e'(kind_i))
            plt_pkg::KIND_ADD: begin
              mode_d = plt_pkg::M_MATCH; add_d = 1'b1; scan_start = 1'b1;
              state_d = plt_pkg::S_SCAN;
            end
            plt_pkg::KIND_GET: begin
              mode_d = plt_pkg::M_GET; add_d = 1'b0; scan_start = 1'b1;
              state_d = plt_pkg::S_SCAN;
            end
            plt_pkg::KIND_PARENT: begin
              mode_d = plt_pkg::M_PARENT; add_d = 1'b0; scan_start = 1'b1;
              state_d = plt_pkg::S_SCAN;
            end
            default: begin
              add_d = 1'b0; age_d = max_age_i; state_d = plt_pkg::S_MUL;
            end
          endcase
        end
      end
      plt_pkg::S_MUL: state_d = plt_pkg::S_SUB;
      plt_pkg::S_SUB: begin
        mode_d = plt_pkg::M_PURGE; scan_start = 1'b1; state_d = plt_pkg::S_SCAN;
      end
      plt_pkg::S_SCAN: begin
        // compaction writes kept entries down to the write pointer
        if (v2_q && keep2_q &&
            (mode_q == plt_pkg::M_PURGE || mode_q == plt_pkg::M_SHIFT)) begin
          mem_we = 1'b1;
        end
        if (scan_done) begin
          case (mode_q)
            plt_pkg::M_MATCH: begin
              if (hit_q) begin
                slot_d = hit_idx_q; state_d = plt_pkg::S_WRITE;
              end else if (fill_q >= CW'(plt_pkg::ENTRIES)) begin
                age_d = evict_q; state_d = plt_pkg::S_MUL;
              end else begin
                slot_d = fill_q[IW-1:0]; fill_d = fill_q + 1'b1;
                state_d = plt_pkg::S_WRITE;
              end
            end
            plt_pkg::M_PURGE: begin
              fill_d = w_q;
              if (!add_q) begin
                state_d = plt_pkg::S_DONE;
              end else if (w_q >= CW'(plt_pkg::ENTRIES)) begin
                mode_d = plt_pkg::M_SHIFT; scan_start = 1'b1;
              end else begin
                slot_d = w_q[IW-1:0]; fill_d = w_q + 1'b1; state_d = plt_pkg::S_WRITE;
              end
            end
            plt_pkg::M_SHIFT: begin
              slot_d = w_q[IW-1:0]; fill_d = w_q + 1'b1; state_d = plt_pkg::S_WRITE;
            end
            default: state_d = plt_pkg::S_DONE;
          endcase
        end
      end
      plt_pkg::S_WRITE: begin
        mem_we = 1'b1; mem_waddr = slot_q; mem_wdata = in_rec_q;
        state_d = plt_pkg::S_DONE;
      end
      plt_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1; state_d = plt_pkg::S_IDLE;
        end
      end
      default: state_d = plt_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= plt_pkg::S_IDLE;
      mode_q      <= plt_pkg::M_MATCH;
      add_q       <= 1'b0;
      fill_q      <= '0;
      evict_q     <= plt_pkg::EVICT_RESET;
      window_q    <= plt_pkg::WINDOW_RESET;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      add_q   <= add_d;
      fill_q  <= fill_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
      if (cfg_we_i) begin
        if (cfg_index_i == plt_pkg::CFG_EVICT) evict_q <= cfg_data_i;
        else                                   window_q <= cfg_data_i;
      end
      if (load_out)         out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // datapath: input capture, cutoff, scan pipeline, result
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    age_q  <= age_d;
    if (accept) begin
      in_rec_q <= '{pid: pid_i, create: create_time_i, exit_t: exit_time_i,
                    exited: exited_i, payload: payload_i};
      ts_q     <= timestamp_i;
      now_q    <= now_sec_i;
    end
    // cutoff = now * 1e9 - age, clamped at zero
    prod_q <= now_q * plt_pkg::NS_PER_SEC;
    cut_q  <= ({1'b0, prod_q} < age_q) ? 63'd0 : ({1'b0, prod_q} - age_q);

    if (scan_start) begin
      rd_q  <= '0;
      w_q   <= '0;
      hit_q <= 1'b0;
    end else begin
      if (issue) rd_q <= rd_q + 1'b1;
      if (v2_q) begin
        case (mode_q)
          plt_pkg::M_MATCH: begin
            if (m_add2_q && !hit_q) begin
              hit_q <= 1'b1; hit_idx_q <= idx2_q;
            end
          end
          plt_pkg::M_GET: begin
            if (m_get2_q && !hit_q) begin
              hit_q <= 1'b1; best_q <= rec2_q;
            end
          end
          plt_pkg::M_PARENT: begin
            if (pre2_q && ({1'b0, ts_q} <= sum2_q) && (!hit_q || diff2_q < near_gap_q)) begin
              hit_q <= 1'b1; best_q <= rec2_q; near_gap_q <= diff2_q;
            end
          end
          default: begin
            if (keep2_q) w_q <= w_q + 1'b1;
          end
        endcase
      end
    end

    // stage one: compare the entry read last cycle
    idx1_q   <= rd_q[IW-1:0];
    idx2_q   <= idx1_q;
    rec2_q   <= rdata;
    m_add2_q <= (rdata.pid == in_rec_q.pid) && (rdata.create == in_rec_q.create);
    m_get2_q <= (rdata.pid == in_rec_q.pid) && (ts_q >= rdata.create) &&
                ((rdata.exit_t == 63'd0) || (ts_q <= rdata.exit_t));
    pre2_q   <= (rdata.pid != in_rec_q.pid) && rdata.exited && (rdata.create <= ts_q);
    sum2_q   <= {1'b0, (rdata.exit_t != 63'd0) ? rdata.exit_t : rdata.create}
                + {1'b0, window_q};
    diff2_q  <= ts_q - rdata.create;
    keep2_q  <= (mode_q == plt_pkg::M_SHIFT) ? (idx1_q != '0) : (rdata.create > cut_q);

    // result word
    if (load_out) begin
      out_status_q <= ((mode_q == plt_pkg::M_GET) || (mode_q == plt_pkg::M_PARENT)) && !hit_q;
      out_rec_q    <= found_ok ? best_q : '0;
      out_count_q  <= 11'(fill_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign found_pid_o     = out_rec_q.pid;
  assign found_create_o  = out_rec_q.create;
  assign found_exit_o    = out_rec_q.exit_t;
  assign found_exited_o  = out_rec_q.exited;
  assign found_payload_o = out_rec_q.payload;
  assign entry_count_o   = out_count_q;

endmodule

// ===== sv/process_lifetime_table_chk.sv =====
// Port-level checker for the process lifetime table, bound to the top level.
// Depends on process_lifetime_table_macros.svh and plt_pkg.
`include "process_lifetime_table_macros.svh"

module process_lifetime_table_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        status_o,
  input logic [31:0] found_pid_o,
  input logic        found_exited_o,
  input logic [63:0] found_payload_o,
  input logic [10:0] entry_count_o
);

  // an accepted word keeps the block busy for the next cycle
  `PLT_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "not busy after accept")

  // a stalled result word holds
  `PLT_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(entry_count_o), "result dropped while stalled")

  // a miss returns an empty record
  `PLT_ASSERT_IMP(a_miss_zero, out_valid_o && status_o, found_pid_o == 32'd0 && !found_exited_o && found_payload_o == 64'd0, "miss carries data")

  // the count never exceeds the table size
  `PLT_ASSERT_IMP(a_count_range, out_valid_o, entry_count_o <= 11'(plt_pkg::ENTRIES), "entry count out of range")

endmodule

bind process_lifetime_table process_lifetime_table_chk u_chk (.*);
